// File: src/pdve_pkg.sv
`timescale 1ns / 1ps

package pdve_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_QMUL,
		ST_VPRE,
		ST_CORDIC,
		ST_HEAD,
		ST_RPRE,
		ST_RPOST,
		ST_RMUL,
		ST_NUM,
		ST_DCHK,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

	localparam int XY_W    = 40;   // CORDIC x/y
	localparam int Z_W     = 34;   // Q30 angle
	localparam int M_W     = 36;   // multiplier operand
	localparam int P_W     = 72;   // multiplier product
	localparam int DEN_W   = 39;   // dt_us * 100 + 1
	localparam int NUM_W   = 62;   // |n| * 1e8
	localparam int D_W     = 85;   // aligned divisor
	localparam int R_W     = 86;   // partial remainder
	localparam int Q_W     = 35;   // quotient with overflow bit
	localparam int QUOT_BITS      = 34;
	localparam int TURN_DEN_SHIFT = 13;

	localparam logic signed [Z_W-1:0]   HALF_PI_Q30 = 34'sd1686629712;
	localparam logic signed [Z_W-1:0]   PI_Q30      = 34'sd3373259424;
	localparam logic signed [XY_W-1:0]  GAIN_K_Q30  = 40'sd652032874;
	localparam logic signed [XY_W-1:0]  ONE_Q28     = 40'sd268435456;
	localparam logic signed [15:0]      PI_Q13      = 16'sd25736;
	localparam logic signed [17:0]      TWO_PI_Q13  = 18'sd51472;
	localparam logic signed [M_W-1:0]   RATE_SCALE  = 36'sd100000000;

	// arctan(2^-i) in Q30, truncated (steps 27 to 30 rounded)
	function automatic logic [31:0] atan_q30(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'h3243F6A8;
			5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC;
			5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76;
			5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA;
			5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA;
			5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F;
			5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F;
			5'd27: v = 32'h00000008;
			5'd28: v = 32'h00000004;
			5'd29: v = 32'h00000002;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

// File: src/pose_difference_velocity_estimator_unit.sv
`timescale 1ns / 1ps

// Channel   Valid      Stall      Payload
// in        in_valid   in_stall   pos_x pos_y quat_x quat_y quat_z quat_w sample_time
// out       out_valid  out_stall  body_vel_x body_vel_y turn_rate heading first_sample
//
// One item at a time. A first sample goes through the shared CORDIC stage in vectoring
// mode only. Later samples go through it for vectoring, then rotation, and then through
// the bit-serial divider (35 steps per velocity, 35 + POS_FRAC_BITS for the turn rate).
// arst_n clears the sequencer, the output valid and the stored previous sample.
// A finished item waits in the output register; the next item is taken meanwhile.

module pose_difference_velocity_estimator_unit #(
	parameter int CORDIC_STEPS  = 16,
	parameter int POS_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	input  logic        [31:0] sample_time,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] body_vel_x,
	output logic signed [31:0] body_vel_y,
	output logic signed [31:0] turn_rate,
	output logic signed [15:0] heading,
	output logic               first_sample
);
	import pdve_pkg::*;

	localparam int IC_W = $clog2(CORDIC_STEPS);
	localparam int DC_W = $clog2(QUOT_BITS + POS_FRAC_BITS + 1);

	state_t state_q, state_d;

	// latched item
	logic signed [31:0] px_q, py_q;
	logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
	logic        [31:0] t_q;

	// previous sample
	logic               have_q;
	logic signed [31:0] prev_x_q, prev_y_q;
	logic signed [15:0] prev_h_q;
	logic        [31:0] prev_t_q;

	// shared multiplier
	logic signed [M_W-1:0] mul_a, mul_b;
	logic signed [P_W-1:0] mul_p, acc_n, acc_q;
	logic        [1:0]     mcnt_q;

	// shared CORDIC stage
	logic signed [XY_W-1:0] x_q, y_q, sh_x, sh_y, x_c, y_c, xn;
	logic signed [Z_W-1:0]  z_q, z_c, yaw_q, atan_v, h_raw, th_adj;
	logic                   rot_q, neg_q, c_pos, th_neg;
	logic        [IC_W-1:0] icnt_q;

	// heading and differences
	logic signed [15:0]      head_q, h_cl;
	logic signed [17:0]      dh_w;
	logic signed [16:0]      dh_c, dh_q;
	logic signed [32:0]      dx_q, dy_q;
	logic        [31:0]      dt;
	logic        [DEN_W-1:0] den_q;
	logic signed [M_W-1:0]   co_q, si_q, bx_q, by_q, val_k, mag_k;

	// divider
	logic        [1:0]       k_q;
	logic                    sgn_q, ovf_q, ge, sat;
	logic        [NUM_W-1:0] num_q;
	logic        [D_W-1:0]   d_val;
	logic        [R_W-1:0]   r_q, r_sub;
	logic        [Q_W-1:0]   quo_q, rnd;
	logic        [Q_W:0]     quo_inc;
	logic        [DC_W-1:0]  dcnt_q;
	logic signed [31:0]      rate_v;
	logic signed [31:0]      res_q [3];
	logic                    first_q;

	// output register
	logic                    out_valid_q, fs_q, slot_free;
	logic signed [31:0]      bvx_q, bvy_q, tr_q;
	logic signed [15:0]      hd_q;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_QMUL: begin
				case (mcnt_q)
					2'd0: begin mul_a = M_W'(qw_q); mul_b = M_W'(qz_q); end
					2'd1: begin mul_a = M_W'(qx_q); mul_b = M_W'(qy_q); end
					2'd2: begin mul_a = M_W'(qy_q); mul_b = M_W'(qy_q); end
					default: begin mul_a = M_W'(qz_q); mul_b = M_W'(qz_q); end
				endcase
			end
			ST_RMUL: begin
				case (mcnt_q)
					2'd0: begin mul_a = co_q; mul_b = M_W'(dx_q); end
					2'd1: begin mul_a = si_q; mul_b = M_W'(dy_q); end
					2'd2: begin mul_a = co_q; mul_b = M_W'(dy_q); end
					default: begin mul_a = -si_q; mul_b = M_W'(dx_q); end
				endcase
			end
			ST_NUM: begin
				mul_a = mag_k;
				mul_b = RATE_SCALE;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign acc_n = mcnt_q[0] ? acc_q + mul_p : mul_p;

	// CORDIC micro-rotation, vectoring or rotation by rot_q
	assign sh_x   = x_q >>> icnt_q;
	assign sh_y   = y_q >>> icnt_q;
	assign atan_v = signed'(Z_W'(atan_q30(5'(icnt_q))));
	assign c_pos  = rot_q ? !z_q[Z_W-1] : y_q[XY_W-1];
	assign x_c    = c_pos ? x_q - sh_y : x_q + sh_y;
	assign y_c    = c_pos ? y_q + sh_x : y_q - sh_x;
	assign z_c    = c_pos ? z_q - atan_v : z_q + atan_v;
	assign xn     = neg_q ? -x_q : x_q;

	// heading from Q30 yaw, rounded and clamped
	assign h_raw = (z_q + Z_W'(65536)) >>> 17;
	always_comb begin
		if (h_raw > Z_W'(PI_Q13))
			h_cl = PI_Q13;
		else if (h_raw < -Z_W'(PI_Q13))
			h_cl = -PI_Q13;
		else
			h_cl = 16'(h_raw);
	end

	// yaw change wrapped into (-pi, pi]
	always_comb begin
		dh_w = 18'(h_cl) - 18'(prev_h_q);
		if (dh_w > 18'(PI_Q13))
			dh_w = dh_w - TWO_PI_Q13;
		else if (dh_w <= -18'(PI_Q13))
			dh_w = dh_w + TWO_PI_Q13;
		dh_c = 17'(dh_w);
	end

	assign dt = t_q - prev_t_q;

	// rotation pre-fold into [-pi/2, pi/2]
	always_comb begin
		th_adj = yaw_q;
		th_neg = 1'b0;
		if (yaw_q > HALF_PI_Q30) begin
			th_adj = yaw_q - PI_Q30;
			th_neg = 1'b1;
		end else if (yaw_q < -HALF_PI_Q30) begin
			th_adj = yaw_q + PI_Q30;
			th_neg = 1'b1;
		end
	end

	// divider datapath
	always_comb begin
		case (k_q)
			2'd0: val_k = bx_q;
			2'd1: val_k = by_q;
			default: val_k = M_W'(dh_q);
		endcase
		mag_k = val_k[M_W-1] ? -val_k : val_k;
	end

	assign d_val   = (k_q == 2'd2) ? D_W'(den_q) << (QUOT_BITS - 1 + TURN_DEN_SHIFT)
	                               : D_W'(den_q) << (QUOT_BITS - 1);
	assign ge      = r_q >= R_W'(d_val);
	assign r_sub   = ge ? r_q - R_W'(d_val) : r_q;
	assign quo_inc = (Q_W + 1)'(quo_q) + (Q_W + 1)'(1);
	assign rnd     = Q_W'(quo_inc >> 1);

	always_comb begin
		if (sgn_q)
			sat = ovf_q || quo_q[Q_W-1] || (rnd > Q_W'(64'h80000000));
		else
			sat = ovf_q || quo_q[Q_W-1] || (rnd > Q_W'(64'h7FFFFFFF));
		if (sat)
			rate_v = sgn_q ? 32'sh80000000 : 32'sh7FFFFFFF;
		else
			rate_v = sgn_q ? -signed'(32'(rnd)) : signed'(32'(rnd));
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_QMUL;
			ST_QMUL:   if (mcnt_q == 2'd3) state_d = ST_VPRE;
			ST_VPRE:   if (x_q == '0 && y_q == '0) state_d = ST_HEAD;
			           else state_d = ST_CORDIC;
			ST_CORDIC: if (icnt_q == IC_W'(CORDIC_STEPS - 1))
			           	state_d = rot_q ? ST_RPOST : ST_HEAD;
			ST_HEAD:   state_d = have_q ? ST_RPRE : ST_OUT;
			ST_RPRE:   state_d = ST_CORDIC;
			ST_RPOST:  state_d = ST_RMUL;
			ST_RMUL:   if (mcnt_q == 2'd3) state_d = ST_NUM;
			ST_NUM:    state_d = ST_DCHK;
			ST_DCHK:   if (R_W'(num_q) >= {d_val, 1'b0}) state_d = ST_FIN;
			           else state_d = ST_DIV;
			ST_DIV:    if (dcnt_q == '0) state_d = ST_FIN;
			ST_FIN:    state_d = (k_q == 2'd2) ? ST_OUT : ST_NUM;
			ST_OUT:    if (slot_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// stored sample and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q      <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_h_q    <= '0;
			prev_t_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_HEAD) begin
				have_q   <= 1'b1;
				prev_x_q <= px_q;
				prev_y_q <= py_q;
				prev_h_q <= h_cl;
				prev_t_q <= t_q;
			end
			if (state_q == ST_OUT && slot_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				px_q   <= pos_x;
				py_q   <= pos_y;
				qx_q   <= quat_x;
				qy_q   <= quat_y;
				qz_q   <= quat_z;
				qw_q   <= quat_w;
				t_q    <= sample_time;
				mcnt_q <= '0;
			end
			ST_QMUL: begin
				acc_q  <= acc_n;
				mcnt_q <= mcnt_q + 2'd1;
				if (mcnt_q == 2'd1)
					y_q <= XY_W'(acc_n) <<< 1;
				if (mcnt_q == 2'd3)
					x_q <= ONE_Q28 - (XY_W'(acc_n) <<< 1);
			end
			ST_VPRE: begin
				icnt_q <= '0;
				rot_q  <= 1'b0;
				z_q    <= '0;
				if (x_q[XY_W-1]) begin
					if (!y_q[XY_W-1]) begin
						x_q <= y_q;
						y_q <= -x_q;
						z_q <= HALF_PI_Q30;
					end else begin
						x_q <= -y_q;
						y_q <= x_q;
						z_q <= -HALF_PI_Q30;
					end
				end
			end
			ST_CORDIC: begin
				x_q    <= x_c;
				y_q    <= y_c;
				z_q    <= z_c;
				icnt_q <= icnt_q + IC_W'(1);
			end
			ST_HEAD: begin
				yaw_q   <= z_q;
				head_q  <= h_cl;
				dx_q    <= 33'(px_q) - 33'(prev_x_q);
				dy_q    <= 33'(py_q) - 33'(prev_y_q);
				dh_q    <= dh_c;
				den_q   <= (DEN_W'(dt) << 6) + (DEN_W'(dt) << 5) + (DEN_W'(dt) << 2)
				           + DEN_W'(1);
				first_q <= !have_q;
				res_q[0] <= '0;
				res_q[1] <= '0;
				res_q[2] <= '0;
			end
			ST_RPRE: begin
				x_q    <= GAIN_K_Q30;
				y_q    <= '0;
				z_q    <= th_adj;
				neg_q  <= th_neg;
				rot_q  <= 1'b1;
				icnt_q <= '0;
			end
			ST_RPOST: begin
				co_q   <= M_W'(xn >>> 2);
				si_q   <= M_W'((neg_q ? -y_q : y_q) >>> 2);
				mcnt_q <= '0;
			end
			ST_RMUL: begin
				acc_q  <= acc_n;
				mcnt_q <= mcnt_q + 2'd1;
				if (mcnt_q == 2'd1)
					bx_q <= M_W'(acc_n >>> 28);
				if (mcnt_q == 2'd3) begin
					by_q <= M_W'(acc_n >>> 28);
					k_q  <= '0;
				end
			end
			ST_NUM: begin
				num_q <= NUM_W'(mul_p);
				sgn_q <= val_k[M_W-1];
			end
			ST_DCHK: begin
				r_q    <= R_W'(num_q);
				quo_q  <= '0;
				ovf_q  <= (R_W'(num_q) >= {d_val, 1'b0});
				dcnt_q <= (k_q == 2'd2) ? DC_W'(QUOT_BITS + POS_FRAC_BITS)
				                        : DC_W'(QUOT_BITS);
			end
			ST_DIV: begin
				r_q    <= r_sub << 1;
				quo_q  <= {quo_q[Q_W-2:0], ge};
				ovf_q  <= ovf_q | quo_q[Q_W-1];
				dcnt_q <= dcnt_q - DC_W'(1);
			end
			ST_FIN: begin
				res_q[k_q] <= rate_v;
				k_q        <= k_q + 2'd1;
			end
			ST_OUT: begin
				if (slot_free) begin
					bvx_q <= res_q[0];
					bvy_q <= res_q[1];
					tr_q  <= res_q[2];
					hd_q  <= head_q;
					fs_q  <= first_q;
				end
			end
			default: begin
				mcnt_q <= mcnt_q;
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign body_vel_x   = bvx_q;
	assign body_vel_y   = bvy_q;
	assign turn_rate    = tr_q;
	assign heading      = hd_q;
	assign first_sample = fs_q;

	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_sample |-> body_vel_x == 0 && body_vel_y == 0 && turn_rate == 0)
		else $error("first item carries nonzero rates");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heading <= PI_Q13 && heading >= -PI_Q13)
		else $error("heading out of range");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("output valid raised outside result load");

	a_cordic_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CORDIC |-> icnt_q <= IC_W'(CORDIC_STEPS - 1))
		else $error("CORDIC step count overrun");

	a_div_prev: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> have_q)
		else $error("divider running without a previous sample");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import pdve_pkg::*;

	// Timing and run limits
	localparam int  HALF_PER    = 2;
	localparam int  N_RANDOM    = 850;
	localparam int  DRAIN_WAIT  = 400;      // well above the worst-case item latency
	localparam int  CYCLE_LIMIT = 2000000;

	// Q30 angle constants and CORDIC setup for the predictor
	localparam int      N_STEPS   = 16;
	localparam int      FRAC_BITS = 16;
	localparam longint  A_PI      = 64'sd3373259424;
	localparam longint  A_HALF_PI = 64'sd1686629712;
	localparam longint  K_GAIN    = 64'sd652032874;
	localparam longint  H_PI      = 64'sd25736;
	localparam longint  H_TWO_PI  = 64'sd51472;
	localparam longint unsigned SCALE_1E8 = 64'd100000000;
	localparam longint unsigned MAG_LIMIT = 64'd4294967296;

	// arctan(2^-i), Q30, truncated
	localparam longint ATAN_Q30 [N_STEPS] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
		64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
		64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
	};

	typedef struct {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] rate;
		logic signed [15:0] hd;
		logic               fs;
	} twist_t;

	// Directed stimulus row; chk marks rows whose result is typed in
	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic signed [15:0] qz;
		logic signed [15:0] qw;
		logic        [31:0] t;
		bit                 chk;
		logic signed [31:0] evx;
		logic signed [31:0] evy;
		logic signed [31:0] erate;
		logic signed [15:0] ehd;
		logic               efs;
	} pose_row_t;

	localparam int N_DIR = 15;
	// quat (0, 0.5, 0.5, 0) makes both atan2 terms zero -> yaw exactly 0
	pose_row_t pose_tab [N_DIR] = '{
		'{32'sd0, 32'sd0, 16'sd0, 16'sd8192, 16'sd8192, 16'sd0, 32'd100,
			1'b1, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 1'b1},
		// same pose, no time elapsed: all rates zero
		'{32'sd0, 32'sd0, 16'sd0, 16'sd8192, 16'sd8192, 16'sd0, 32'd100,
			1'b1, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 1'b0},
		'{32'sd65536, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 32'd1100,
			1'b0, 0, 0, 0, 0, 0},
		// position extremes, zero dt -> saturation
		'{32'h7FFFFFFF, 32'h7FFFFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 32'd1100,
			1'b0, 0, 0, 0, 0, 0},
		'{32'h80000000, 32'h80000000, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 32'd1101,
			1'b0, 0, 0, 0, 0, 0},
		// yaw +pi, then just above -pi: heading change wraps
		'{32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 32'd2101,
			1'b0, 0, 0, 0, 0, 0},
		'{32'sd0, 32'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd1, 32'd3101,
			1'b0, 0, 0, 0, 0, 0},
		'{32'sd100, -32'sd100, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
			32'hFFFFFF00, 1'b0, 0, 0, 0, 0, 0},
		// timestamp wraps past 2^32
		'{32'sd200, -32'sd200, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384,
			32'h00000100, 1'b0, 0, 0, 0, 0, 0},
		'{32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd500,
			1'b0, 0, 0, 0, 0, 0},
		'{32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd11585, 16'sd11585, 32'd600,
			1'b0, 0, 0, 0, 0, 0},
		'{32'sd0, 32'sd0, 16'sd0, 16'sd0, -16'sd11585, 16'sd11585, 32'd700,
			1'b0, 0, 0, 0, 0, 0},
		// negative cosine term -> left half plane prerotation
		'{32'sd5, 32'sd5, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 32'd800,
			1'b0, 0, 0, 0, 0, 0},
		'{32'sd0, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, -16'sd16384, 32'd900,
			1'b0, 0, 0, 0, 0, 0},
		'{32'h12345678, 32'hEDCBA987, -16'sd1, 16'sd1, -16'sd16384, 16'sd16384,
			32'hFFFFFFFF, 1'b0, 0, 0, 0, 0, 0}
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;
	logic        [31:0] sample_time;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] body_vel_x;
	logic signed [31:0] body_vel_y;
	logic signed [31:0] turn_rate;
	logic signed [15:0] heading;
	logic               first_sample;

	pose_difference_velocity_estimator_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.quat_x       (quat_x),
		.quat_y       (quat_y),
		.quat_z       (quat_z),
		.quat_w       (quat_w),
		.sample_time  (sample_time),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.body_vel_x   (body_vel_x),
		.body_vel_y   (body_vel_y),
		.turn_rate    (turn_rate),
		.heading      (heading),
		.first_sample (first_sample)
	);

	// Predictor state: mirror of the stored previous sample
	bit                 seen_pose = 1'b0;
	longint             last_x = 0;
	longint             last_y = 0;
	longint             last_hd = 0;
	logic        [31:0] last_t = '0;

	twist_t twist_q[$];     // expected results, oldest first
	twist_t typed_q[$];     // typed-in results for directed rows
	bit     typed_flag_q[$];

	int  n_taken = 0;
	int  n_errors = 0;
	int  cycles = 0;

	// Yaw of vector (c, s) in Q30 by vectoring CORDIC
	function automatic longint yaw_of(longint c, longint s);
		longint x, y, z, dx, dy;
		if (c == 0 && s == 0)
			return 0;
		x = c;
		y = s;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				x = s;
				y = -c;
				z = A_HALF_PI;
			end else begin
				x = -s;
				y = c;
				z = -A_HALF_PI;
			end
		end
		for (int i = 0; i < N_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += ATAN_Q30[i];
			end else begin
				x -= dx;
				y += dy;
				z -= ATAN_Q30[i];
			end
		end
		return z;
	endfunction

	// cos and sin of a Q30 angle, Q28, by rotation CORDIC
	function automatic void rotate_unit(input longint ang, output longint co,
			output longint si);
		longint x, y, th, dx, dy;
		bit     flip;
		x = K_GAIN;
		y = 0;
		th = ang;
		flip = 0;
		if (th > A_HALF_PI) begin
			th -= A_PI;
			flip = 1;
		end else if (th < -A_HALF_PI) begin
			th += A_PI;
			flip = 1;
		end
		for (int i = 0; i < N_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (th >= 0) begin
				x -= dx;
				y += dy;
				th -= ATAN_Q30[i];
			end else begin
				x += dx;
				y -= dy;
				th += ATAN_Q30[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		co = x >>> 2;
		si = y >>> 2;
	endfunction

	// round(num * 2^sh / den), magnitude capped
	function automatic longint unsigned quot_round(longint unsigned num, int sh,
			longint unsigned den);
		longint unsigned q, r;
		q = num / den;
		r = num % den;
		if (q > MAG_LIMIT)
			return MAG_LIMIT;
		for (int i = 0; i < sh + 1; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r -= den;
				q |= 1;
			end
			if (q > (MAG_LIMIT << 2))
				return MAG_LIMIT;
		end
		q = (q + 1) >> 1;
		return (q > MAG_LIMIT) ? MAG_LIMIT : q;
	endfunction

	function automatic logic signed [31:0] rate_of(longint n, int sh, longint unsigned den);
		longint unsigned mag;
		mag = quot_round(longint'(n < 0 ? -n : n) * SCALE_1E8, sh, den);
		if (n < 0)
			return (mag > 64'd2147483648) ? 32'h80000000 : 32'(-longint'(mag));
		return (mag > 64'd2147483647) ? 32'h7FFFFFFF : 32'(mag);
	endfunction

	// Twist for one pose sample; updates the stored previous sample
	function automatic twist_t twist_of(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [15:0] qx, logic signed [15:0] qy, logic signed [15:0] qz,
			logic signed [15:0] qw, logic [31:0] t);
		twist_t          res;
		longint          s, c, yaw, h, dx, dy, co, si, bx, by, dh;
		longint unsigned den;
		logic     [31:0] dt;
		s = 2 * (longint'(qw) * qz + longint'(qx) * qy);
		c = (longint'(1) << 28) - 2 * (longint'(qy) * qy + longint'(qz) * qz);
		yaw = yaw_of(c, s);
		h = (yaw + (longint'(1) << 16)) >>> 17;
		if (h > H_PI)
			h = H_PI;
		if (h < -H_PI)
			h = -H_PI;
		res.hd = 16'(h);
		if (!seen_pose) begin
			res.vx = 0;
			res.vy = 0;
			res.rate = 0;
			res.fs = 1;
		end else begin
			dx = longint'(px) - last_x;
			dy = longint'(py) - last_y;
			dt = t - last_t;
			den = longint'({32'b0, dt}) * 100 + 1;
			rotate_unit(yaw, co, si);
			bx = (co * dx + si * dy) >>> 28;
			by = (co * dy - si * dx) >>> 28;
			dh = h - last_hd;
			if (dh > H_PI)
				dh -= H_TWO_PI;
			if (dh <= -H_PI)
				dh += H_TWO_PI;
			res.vx = rate_of(bx, 0, den);
			res.vy = rate_of(by, 0, den);
			res.rate = rate_of(dh, FRAC_BITS, den << 13);
			res.fs = 0;
		end
		seen_pose = 1;
		last_x = px;
		last_y = py;
		last_hd = h;
		last_t = t;
		return res;
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	always #(HALF_PER) clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("pose_difference_velocity_estimator_unit test failed");
			$finish;
		end
	end

	// Input side: predict at the edge where the item is taken
	always @(posedge clk) begin
		twist_t pred;
		twist_t typed;
		bit     use_typed;
		if (arst_n && in_valid && !in_stall) begin
			pred = twist_of(pos_x, pos_y, quat_x, quat_y, quat_z, quat_w, sample_time);
			use_typed = typed_flag_q.pop_front();
			typed = typed_q.pop_front();
			twist_q.push_back(use_typed ? typed : pred);
			n_taken <= n_taken + 1;
		end
	end

	// Output side: compare each taken item with the oldest expectation
	always @(posedge clk) begin
		twist_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (twist_q.size() == 0) begin
				$display("%0t: unexpected result vx=%0d vy=%0d rate=%0d hd=%0d fs=%0b",
					$time, body_vel_x, body_vel_y, turn_rate, heading, first_sample);
				n_errors++;
			end else begin
				want = twist_q.pop_front();
				if (body_vel_x !== want.vx) begin
					$display("%0t: body_vel_x exp %0d got %0d", $time, want.vx, body_vel_x);
					n_errors++;
				end
				if (body_vel_y !== want.vy) begin
					$display("%0t: body_vel_y exp %0d got %0d", $time, want.vy, body_vel_y);
					n_errors++;
				end
				if (turn_rate !== want.rate) begin
					$display("%0t: turn_rate exp %0d got %0d", $time, want.rate, turn_rate);
					n_errors++;
				end
				if (heading !== want.hd) begin
					$display("%0t: heading exp %0d got %0d", $time, want.hd, heading);
					n_errors++;
				end
				if (first_sample !== want.fs) begin
					$display("%0t: first_sample exp %0b got %0b", $time, want.fs,
						first_sample);
					n_errors++;
				end
			end
		end
	end

	// Output stall: random holds, with quiet stretches
	int stall_left = 0;
	int stall_mode = 1;
	always @(negedge clk) begin
		if (cycles % 300 == 0)
			stall_mode = $urandom_range(0, 2);
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (stall_mode != 0 && $urandom_range(0, 3) == 0) begin
			stall_left = pick_gap();
			out_stall <= (stall_left > 0);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Drive one item and hold it until taken
	task automatic send_pose(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [15:0] qx, logic signed [15:0] qy, logic signed [15:0] qz,
			logic signed [15:0] qw, logic [31:0] t, bit chk, twist_t typed, int gap);
		int start;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		typed_flag_q.push_back(chk);
		typed_q.push_back(typed);
		pos_x <= px;
		pos_y <= py;
		quat_x <= qx;
		quat_y <= qy;
		quat_z <= qz;
		quat_w <= qw;
		sample_time <= t;
		in_valid <= 1'b1;
		start = n_taken;
		do @(negedge clk); while (n_taken == start);
	endtask

	initial begin
		twist_t             typed;
		logic signed [31:0] cx, cy;
		logic        [31:0] ct;
		int                 burst;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		pos_x = '0;
		pos_y = '0;
		quat_x = '0;
		quat_y = '0;
		quat_z = '0;
		quat_w = '0;
		sample_time = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part
		foreach (pose_tab[i]) begin
			typed.vx = pose_tab[i].evx;
			typed.vy = pose_tab[i].evy;
			typed.rate = pose_tab[i].erate;
			typed.hd = pose_tab[i].ehd;
			typed.fs = pose_tab[i].efs;
			send_pose(pose_tab[i].x, pose_tab[i].y, pose_tab[i].qx, pose_tab[i].qy,
				pose_tab[i].qz, pose_tab[i].qw, pose_tab[i].t, pose_tab[i].chk, typed,
				pick_gap());
		end

		// random part: mostly smooth trajectories, some noise
		cx = $urandom;
		cy = $urandom;
		ct = $urandom;
		burst = 0;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 100 == 0)
				burst = $urandom_range(0, 3) == 0;
			// hold off until the block has drained
			if (n == N_RANDOM / 2) begin
				in_valid <= 1'b0;
				while (twist_q.size() != 0) @(negedge clk);
				repeat (DRAIN_WAIT) @(negedge clk);
			end
			if ($urandom_range(0, 99) < 85) begin
				cx += $signed($urandom_range(0, 1 << 20)) - (1 << 19);
				cy += $signed($urandom_range(0, 1 << 20)) - (1 << 19);
				ct += ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1000, 200000);
				send_pose(cx, cy,
					16'($signed($urandom_range(0, 1000)) - 500),
					16'($signed($urandom_range(0, 1000)) - 500),
					16'($signed($urandom_range(0, 32768)) - 16384),
					16'($signed($urandom_range(0, 32768)) - 16384),
					ct, 1'b0, typed, burst ? 0 : pick_gap());
			end else begin
				cx = $urandom;
				cy = $urandom;
				ct = $urandom;
				send_pose(cx, cy,
					16'($signed($urandom_range(0, 32768)) - 16384),
					16'($signed($urandom_range(0, 32768)) - 16384),
					16'($signed($urandom_range(0, 32768)) - 16384),
					16'($signed($urandom_range(0, 32768)) - 16384),
					ct, 1'b0, typed, burst ? 0 : pick_gap());
			end
		end
		in_valid <= 1'b0;

		while (twist_q.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (n_errors == 0)
			$display("pose_difference_velocity_estimator_unit test passed");
		else
			$display("pose_difference_velocity_estimator_unit test failed");
		$finish;
	end

endmodule
